// ===== design/unat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unat_pkg
// Shared types and constants for the UDP address/port translator.
// ----------------------------------------------------------------------------
package unat_pkg;
    localparam logic [7:0]  PORT_PRIVATE = 8'd1;
    localparam logic [7:0]  PORT_PUBLIC  = 8'd2;
    localparam logic [47:0] BCAST_MAC    = 48'hffff_ffff_ffff;

    localparam logic [2:0] CFG_SWITCH  = 3'd0;
    localparam logic [2:0] CFG_PUB_IP  = 3'd1;
    localparam logic [2:0] CFG_BASE    = 3'd2;
    localparam logic [2:0] CFG_PUB_MAC = 3'd3;
    localparam logic [2:0] CFG_PRV_MAC = 3'd4;

    // probe carried down the cell row
    typedef struct packed {
        logic        active;
        logic        inbound;
        logic [63:0] addrs;
        logic [31:0] ports;
        logic        hit;
        logic [31:0] res_addr;
        logic [15:0] res_port;
    } probe_t;

    // new entry written into the cell at the fill position
    typedef struct packed {
        logic        en;
        logic [63:0] out_addrs;
        logic [31:0] out_ports;
        logic [15:0] new_port;
        logic [63:0] in_addrs;
        logic [31:0] in_ports;
        logic [31:0] orig_addr;
        logic [15:0] orig_port;
    } entry_t;
endpackage

// ===== design/unat_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unat_cell
// One flow entry: outbound and reverse keys, compared against a passing probe.
// ----------------------------------------------------------------------------
module unat_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_sel,
    input  unat_pkg::entry_t wr,
    input  unat_pkg::probe_t probe_in,
    output unat_pkg::probe_t probe_out
);
    import unat_pkg::*;

    logic        valid_reg;
    logic [63:0] oa_reg, ia_reg;
    logic [31:0] op_reg, ip_reg, orig_a_reg;
    logic [15:0] np_reg, orig_p_reg;
    probe_t      probe_reg, probe_next;

    always_comb begin
        logic match;
        probe_next = probe_in;
        match = probe_in.inbound ? (ia_reg == probe_in.addrs && ip_reg == probe_in.ports)
                                 : (oa_reg == probe_in.addrs && op_reg == probe_in.ports);
        if (probe_in.active && !probe_in.hit && valid_reg && match) begin
            probe_next.hit      = 1'b1;
            probe_next.res_addr = orig_a_reg;
            probe_next.res_port = probe_in.inbound ? orig_p_reg : np_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg        <= 1'b0;
            probe_reg.active <= 1'b0;
        end else begin
            probe_reg <= probe_next;
            if (wr.en && wr_sel) begin
                valid_reg <= 1'b1;
            end
        end
        if (wr.en && wr_sel) begin
            oa_reg     <= wr.out_addrs;
            op_reg     <= wr.out_ports;
            np_reg     <= wr.new_port;
            ia_reg     <= wr.in_addrs;
            ip_reg     <= wr.in_ports;
            orig_a_reg <= wr.orig_addr;
            orig_p_reg <= wr.orig_port;
        end
    end

    assign probe_out = probe_reg;
endmodule

// ===== design/udp_nat_translator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_nat_translator
// UDP NAT for one switch: outbound flow allocation, inbound reverse lookup.
// ----------------------------------------------------------------------------
// One header request at a time. Its lookup key walks a row of TABLE_DEPTH
// cells, one cell per cycle, and the result is registered when the key leaves
// the last cell. The result is then held until m_tready takes it, and the
// block returns to idle before it accepts the next request. On an outbound
// miss the new entry is written into the next free cell as the walk ends.
// Valid bits clear at reset; no clearing pass.
module udp_nat_translator #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // switch_id, ingress_port, is_ipv4, is_udp, src_ip, dst_ip, src_port, dst_port
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // verdict, egress_port, out_src_ip, out_dst_ip, out_src_port, out_dst_port,
    // out_src_mac, out_dst_mac, checksum_cleared, table_full
    output logic [207:0] m_tdata
);
    import unat_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0, ST_WALK = 2'd1, ST_OUT = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [15:0] sw_reg;
    logic [31:0] pip_reg;
    logic [15:0] base_reg;
    logic [47:0] pmac_reg, vmac_reg;
    logic [15:0] issued_reg;
    logic [CW-1:0] used_reg;
    logic [CW-1:0] cnt_reg;
    logic [127:0] hdr_reg;
    logic [207:0] res_reg;

    probe_t chain [0:TABLE_DEPTH];
    entry_t wr;
    logic [IW-1:0] wr_idx;

    logic [15:0] h_sw;
    logic [7:0]  h_port;
    logic        h_v4, h_udp;
    logic [31:0] h_sip, h_dip;
    logic [15:0] h_sp, h_dp;
    assign h_sw = hdr_reg[15:0];
    assign h_port = hdr_reg[23:16];
    assign h_v4 = hdr_reg[24];
    assign h_udp = hdr_reg[25];
    assign h_sip = hdr_reg[57:26];
    assign h_dip = hdr_reg[89:58];
    assign h_sp = hdr_reg[105:90];
    assign h_dp = hdr_reg[121:106];

    probe_t start;
    always_comb begin
        start          = '0;
        start.active   = (state_reg == ST_IDLE) && s_tvalid;
        start.inbound  = s_tdata[23:16] == PORT_PUBLIC;
        start.addrs    = {s_tdata[57:26], s_tdata[89:58]};
        start.ports    = {s_tdata[105:90], s_tdata[121:106]};
    end
    assign chain[0] = start;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            unat_cell u_cell (
                .aclk(aclk), .aresetn(aresetn),
                .wr_sel(wr_idx == IW'(g)), .wr(wr),
                .probe_in(chain[g]), .probe_out(chain[g+1])
            );
        end
    endgenerate

    probe_t fin;
    assign fin = chain[TABLE_DEPTH];
    assign wr_idx = used_reg[IW-1:0];
    logic [16:0] np_sum;
    assign np_sum = {1'b0, base_reg} + {1'b0, issued_reg};

    logic [207:0] res_next;
    logic         alloc;
    always_comb begin
        logic ok;
        res_next = '0;
        alloc    = 1'b0;
        wr       = '0;
        ok = (h_sw == sw_reg) && h_v4 && h_udp;
        if (ok && h_port == PORT_PRIVATE) begin
            if (!fin.hit && (used_reg >= CW'(TABLE_DEPTH) || issued_reg == 16'hffff
                    || np_sum[16])) begin
                res_next[202] = 1'b1;
            end else begin
                alloc = !fin.hit;
                res_next[0] = 1'b1;
                res_next[8:1] = PORT_PUBLIC;
                res_next[40:9] = pip_reg;
                res_next[72:41] = h_dip;
                res_next[88:73] = fin.hit ? fin.res_port : np_sum[15:0];
                res_next[104:89] = h_dp;
                res_next[152:105] = pmac_reg;
                res_next[200:153] = BCAST_MAC;
                res_next[201] = 1'b1;
            end
        end else if (ok && h_port == PORT_PUBLIC && fin.hit) begin
            res_next[0] = 1'b1;
            res_next[8:1] = PORT_PRIVATE;
            res_next[40:9] = h_sip;
            res_next[72:41] = fin.res_addr;
            res_next[88:73] = h_sp;
            res_next[104:89] = fin.res_port;
            res_next[152:105] = vmac_reg;
            res_next[200:153] = BCAST_MAC;
            res_next[201] = 1'b1;
        end
        wr.en        = (state_reg == ST_WALK) && (cnt_reg == CW'(TABLE_DEPTH)) && alloc;
        wr.out_addrs = {h_sip, h_dip};
        wr.out_ports = {h_sp, h_dp};
        wr.new_port  = np_sum[15:0];
        wr.in_addrs  = {h_dip, pip_reg};
        wr.in_ports  = {h_dp, np_sum[15:0]};
        wr.orig_addr = h_sip;
        wr.orig_port = h_sp;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = res_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_WALK;
            ST_WALK: if (cnt_reg == CW'(TABLE_DEPTH)) state_next = ST_OUT;
            ST_OUT:  if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sw_reg     <= 16'd1;
            pip_reg    <= 32'h0b0b0b0b;
            base_reg   <= 16'd2000;
            pmac_reg   <= BCAST_MAC;
            vmac_reg   <= BCAST_MAC;
            issued_reg <= '0;
            used_reg   <= '0;
            cnt_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_SWITCH:  sw_reg   <= cfg_data[15:0];
                    CFG_PUB_IP:  pip_reg  <= cfg_data[31:0];
                    CFG_BASE:    base_reg <= cfg_data[15:0];
                    CFG_PUB_MAC: pmac_reg <= cfg_data;
                    CFG_PRV_MAC: vmac_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_IDLE) cnt_reg <= CW'(1);
            else if (state_reg == ST_WALK) cnt_reg <= cnt_reg + CW'(1);
            if (wr.en) begin
                used_reg   <= used_reg + CW'(1);
                issued_reg <= issued_reg + 16'd1;
            end
        end
        if (state_reg == ST_IDLE && s_tvalid) hdr_reg <= s_tdata;
        if (state_reg == ST_WALK && cnt_reg == CW'(TABLE_DEPTH)) res_reg <= res_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CW'(TABLE_DEPTH)) else $error("fill count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |=> used_reg == $past(used_reg) + CW'(1)) else $error("fill count");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("overlap");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(res_reg[0] && res_reg[202])) else $error("full on forward");
endmodule
